>>> hw/rtl/smdb_pkg.sv
`timescale 1ns / 1ps

package smdb_pkg;

  localparam int LOG_TABLE_BITS = 8;
  localparam int ROM_N = (1 << LOG_TABLE_BITS) + 1;
  localparam int ROM_IDX_W = LOG_TABLE_BITS + 1;

  localparam int SUM_W = 63;
  localparam int CNT_W = 32;
  localparam int CFG_W = 15;
  localparam int LVL_W = 15;
  localparam int PCT_W = 7;
  localparam int LOG_W = 38;
  localparam int D20_W = 26;
  localparam int PROD_W = 52;
  localparam int RAW_W = 18;
  localparam int NUM_W = 22;

  localparam logic [25:0] K_Q16 = 26'd50504453;
  localparam logic [28:0] OFF_Q16 = 29'd398851483;

  // stage numbers of the top level pipeline
  localparam int LOG_LAT = 6;
  localparam int DIV_STEPS = PCT_W;
  localparam int DIFF_STAGE = LOG_LAT + 1;
  localparam int MUL_STAGE = DIFF_STAGE + 1;
  localparam int LVL_STAGE = MUL_STAGE + 1;
  localparam int PCT_STAGE = LVL_STAGE + 1;
  localparam int PIPE_DEPTH = PCT_STAGE + DIV_STEPS + 1;

  typedef enum logic [0:0] {
    REG_FLOOR = 1'b0,
    REG_CEIL  = 1'b1
  } reg_idx_t;

  typedef logic [32:0] rom_t [ROM_N];

  // log2(1 + i/2^LOG_TABLE_BITS) in Q32 by repeated squaring
  function automatic logic [32:0] rom_entry(int i);
    logic [63:0] y;
    logic [32:0] r;
    if (i >= (1 << LOG_TABLE_BITS)) begin
      return 33'h1_0000_0000;
    end
    y = 64'h8000_0000 + (64'(i) << (31 - LOG_TABLE_BITS));
    r = '0;
    for (int k = 0; k < 32; k++) begin
      y = (y * y) >> 31;
      r = r << 1;
      if (y >= 64'h1_0000_0000) begin
        r[0] = 1'b1;
        y = y >> 1;
      end
    end
    return r;
  endfunction

  function automatic rom_t make_rom();
    rom_t r;
    for (int i = 0; i < ROM_N; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = make_rom();

endpackage

>>> hw/rtl/smdb_log.sv
`timescale 1ns / 1ps

module smdb_log (
  input  logic                        clk,
  input  logic                        en,
  input  logic [smdb_pkg::SUM_W-1:0]  x,
  output logic [smdb_pkg::LOG_W-1:0]  log2_q32
);

  localparam int TB = smdb_pkg::LOG_TABLE_BITS;
  localparam logic [TB:0] ROM_ONE = (TB + 1)'(1);

  logic [smdb_pkg::SUM_W-1:0] x1;
  logic [2:0]                 grp1;
  logic [2:0]                 grp_c;
  logic [63:0]                xp;

  logic [smdb_pkg::SUM_W-1:0] x2;
  logic [5:0]                 e2;
  logic [2:0]                 bit_c;
  logic [63:0]                xp1;
  logic [7:0]                 byte_c;

  logic [smdb_pkg::SUM_W-1:0] m_c;
  logic [TB-1:0]              idx3;
  logic [31:0]                t3;
  logic [5:0]                 e3;

  logic [32:0]                a_c;
  logic [32:0]                b_c;
  logic [32:0]                a4;
  logic [32:0]                dif4;
  logic [31:0]                t4;
  logic [5:0]                 e4;

  logic [64:0]                prod_c;
  logic [32:0]                ph5;
  logic [32:0]                a5;
  logic [5:0]                 e5;

  // coarse search: highest nonzero byte
  assign xp = {1'b0, x};
  always_comb begin
    grp_c = '0;
    for (int k = 0; k < 8; k++) begin
      if (xp[k*8 +: 8] != 8'd0) grp_c = 3'(k);
    end
  end

  // fine search inside that byte
  assign xp1 = {1'b0, x1};
  assign byte_c = xp1[{grp1, 3'b000} +: 8];
  always_comb begin
    bit_c = '0;
    for (int k = 0; k < 8; k++) begin
      if (byte_c[k]) bit_c = 3'(k);
    end
  end

  assign m_c = x2 << (6'd62 - e2);

  assign a_c = smdb_pkg::LOG_ROM[{1'b0, idx3}];
  assign b_c = smdb_pkg::LOG_ROM[{1'b0, idx3} + ROM_ONE];

  assign prod_c = 65'(dif4) * 65'(t4);

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      grp1 <= grp_c;
      x2 <= x1;
      e2 <= {grp1, bit_c};
      idx3 <= m_c[61 -: TB];
      t3 <= m_c[61-TB -: 32];
      e3 <= e2;
      a4 <= a_c;
      dif4 <= (b_c > a_c) ? (b_c - a_c) : '0;
      t4 <= t3;
      e4 <= e3;
      ph5 <= prod_c[64:32];
      a5 <= a4;
      e5 <= e4;
      log2_q32 <= {e5, 32'd0} + smdb_pkg::LOG_W'(a5) + smdb_pkg::LOG_W'(ph5);
    end
  end

endmodule

>>> hw/rtl/smdb_div.sv
`timescale 1ns / 1ps

module smdb_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [smdb_pkg::NUM_W-1:0]   num,
  input  logic [smdb_pkg::CFG_W-1:0]   den,
  output logic [smdb_pkg::PCT_W-1:0]   quo
);

  localparam int N = smdb_pkg::DIV_STEPS;
  localparam int NW = smdb_pkg::NUM_W;
  localparam int DW = smdb_pkg::CFG_W;
  localparam int QW = smdb_pkg::PCT_W;

  logic [NW-1:0] rem [N-1];
  logic [DW-1:0] dv  [N-1];
  logic [QW-1:0] q   [N];

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int SH = N - 1 - j;
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [NW-1:0] dsh;
    logic          fits;

    if (j == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[j-1];
      assign d_in = dv[j-1];
      assign q_in = q[j-1];
    end

    assign dsh = NW'(d_in) << SH;
    assign fits = (r_in >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        q[j] <= fits ? (q_in | (QW'(1) << SH)) : q_in;
      end
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= fits ? (r_in - dsh) : r_in;
          dv[j] <= d_in;
        end
      end
    end
  end

  assign quo = q[N-1];

endmodule

>>> hw/rtl/sum_of_squares_to_db_meter.sv
`timescale 1ns / 1ps

// throughput: one item per cycle; the pipeline stalls as a whole only while the
//   output register holds a result that is not taken
// reset: rst clears all valid bits and loads floor 7680 and ceiling 23040
module sum_of_squares_to_db_meter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smdb_pkg::SUM_W-1:0]        sum_sq,
  input  logic [smdb_pkg::CNT_W-1:0]        sample_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [smdb_pkg::LVL_W-1:0]        level_db_x256,
  output logic [smdb_pkg::PCT_W-1:0]        level_percent,
  output logic                              floor_forced,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [smdb_pkg::CFG_W-1:0]        cfg_data
);

  localparam int D = smdb_pkg::PIPE_DEPTH;
  localparam int LS = smdb_pkg::LVL_STAGE;

  logic                           adv;
  logic [smdb_pkg::CFG_W-1:0]     db_floor;
  logic [smdb_pkg::CFG_W-1:0]     db_ceil;

  logic [D-1:0]                   vld;
  logic [D-1:0]                   frc;
  logic [smdb_pkg::LVL_W-1:0]     lvl_line [LS:D-1];

  logic [smdb_pkg::SUM_W-1:0]     s0;
  logic [smdb_pkg::CNT_W-1:0]     n0;
  logic                           forced_c;

  logic [smdb_pkg::LOG_W-1:0]     ls;
  logic [smdb_pkg::LOG_W-1:0]     ln;
  logic [smdb_pkg::LOG_W-1:0]     ldiff;
  logic [smdb_pkg::D20_W-1:0]     d20;
  logic [smdb_pkg::PROD_W-1:0]    mprod;
  logic [53:0]                    vsum;
  logic [smdb_pkg::RAW_W-1:0]     raw;
  logic [smdb_pkg::LVL_W-1:0]     lvl_c;

  logic                           pct_ok;
  logic [smdb_pkg::NUM_W-1:0]     num;
  logic [smdb_pkg::CFG_W-1:0]     den;
  logic [smdb_pkg::PCT_W-1:0]     quo;

  assign adv = !vld[D-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      db_floor <= smdb_pkg::CFG_W'(7680);
      db_ceil <= smdb_pkg::CFG_W'(23040);
    end else if (cfg_we) begin
      case (smdb_pkg::reg_idx_t'(cfg_index))
        smdb_pkg::REG_FLOOR: db_floor <= cfg_data;
        smdb_pkg::REG_CEIL:  db_ceil <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[D-2:0], in_valid};
    end
  end

  // mean below one or empty window
  assign forced_c = (sample_count == '0) ||
                    (sum_sq < smdb_pkg::SUM_W'(sample_count));

  always_ff @(posedge clk) begin
    if (adv) begin
      frc <= {frc[D-2:0], forced_c};
      s0 <= sum_sq;
      n0 <= sample_count;
    end
  end

  smdb_log u_log_s (
    .clk      (clk),
    .en       (adv),
    .x        (s0),
    .log2_q32 (ls)
  );

  smdb_log u_log_n (
    .clk      (clk),
    .en       (adv),
    .x        (smdb_pkg::SUM_W'(n0)),
    .log2_q32 (ln)
  );

  assign ldiff = ls - ln;
  assign vsum = 54'(mprod) + (54'(smdb_pkg::OFF_Q16) << 20) + (54'(1) << 35);
  assign raw = vsum[53:36];

  always_comb begin
    if (frc[LS-1]) begin
      lvl_c = db_floor;
    end else if (raw < smdb_pkg::RAW_W'(db_floor)) begin
      // ceiling still wins when it lies below the floor
      lvl_c = (db_floor > db_ceil) ? db_ceil : db_floor;
    end else if (raw > smdb_pkg::RAW_W'(db_ceil)) begin
      lvl_c = db_ceil;
    end else begin
      lvl_c = raw[smdb_pkg::LVL_W-1:0];
    end
  end

  assign pct_ok = (db_ceil > db_floor) && (lvl_line[LS] > db_floor);

  always_ff @(posedge clk) begin
    if (adv) begin
      d20 <= (ls > ln) ? ldiff[smdb_pkg::LOG_W-1:12] : '0;
      mprod <= smdb_pkg::PROD_W'(d20) * smdb_pkg::PROD_W'(smdb_pkg::K_Q16);
      lvl_line[LS] <= lvl_c;
      for (int i = LS + 1; i < D; i++) begin
        lvl_line[i] <= lvl_line[i-1];
      end
      num <= pct_ok ? smdb_pkg::NUM_W'((smdb_pkg::NUM_W'(lvl_line[LS] - db_floor)) * 7'd100)
                    : '0;
      den <= pct_ok ? (db_ceil - db_floor) : '1;
    end
  end

  smdb_div u_div (
    .clk (clk),
    .en  (adv),
    .num (num),
    .den (den),
    .quo (quo)
  );

  assign out_valid = vld[D-1];
  assign level_db_x256 = lvl_line[D-1];
  assign level_percent = quo;
  assign floor_forced = frc[D-1];

endmodule
